/* hw/rtl/s5hs_pkg.sv */
// Shared types and constants for the SOCKS5 connect handshake core.
`default_nettype none

package s5hs_pkg;

	localparam int unsigned ReplyMax = 10;
	localparam int unsigned IdxW = $clog2(ReplyMax);

	localparam logic [7:0] SocksVer     = 8'h05;
	localparam logic [7:0] CmdConnect   = 8'h01;
	localparam logic [7:0] RsvByte      = 8'h00;
	localparam logic [7:0] MethodNoAuth = 8'h00;
	localparam logic [7:0] AtypV4       = 8'h01;
	localparam logic [7:0] AtypV6       = 8'h04;
	localparam logic [7:0] RepSuccess   = 8'h00;
	localparam logic [7:0] RepGenFail   = 8'h01;

	// address plus port byte counts
	localparam logic [4:0] DestLenV4 = 5'd6;
	localparam logic [4:0] DestLenV6 = 5'd18;

	localparam logic [4:0] ReqHdrLast = 5'd3;

	typedef enum logic [2:0] {
		PH_GREET_HDR = 3'd0,
		PH_METHODS   = 3'd1,
		PH_REQ_HDR   = 3'd2,
		PH_DEST      = 3'd3,
		PH_OUTCOME   = 3'd4,
		PH_FORWARD   = 3'd5,
		PH_FAIL      = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		K_REPLY    = 3'd0,
		K_FORWARD  = 3'd1,
		K_DEST     = 3'd2,
		K_FAILED   = 3'd3,
		K_NOTREADY = 3'd4
	} kind_t;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  in_byte;
		logic        connect_ok;
		logic        bound_ok;
		logic [31:0] bound_addr;
		logic [15:0] bound_port;
	} in_item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] out_byte;
		logic       addr_is_v6;
		logic       last;
	} out_item_t;

	// one run of result words produced by a single input word
	typedef struct packed {
		kind_t                         kind;
		logic                          v6;
		logic                          last_flag;
		logic [IdxW-1:0]               len;
		logic [ReplyMax-1:0][7:0]      bytes;
	} burst_t;

endpackage

`default_nettype wire

/* hw/rtl/s5hs_fsm.sv */
// Handshake phase tracking and per-word decode into a result run.
`default_nettype none

module s5hs_fsm (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                go,
	input  wire s5hs_pkg::in_item_t  item,
	output s5hs_pkg::burst_t         burst
);

	s5hs_pkg::phase_t phase_q, phase_n;
	logic [4:0] byte_count_q, byte_count_n;
	logic [7:0] methods_left_q, methods_left_n;
	logic       no_auth_q, no_auth_n;
	logic       dest_v6_q, dest_v6_n;

	logic       fail;
	logic [7:0] b;
	logic [7:0] ml_dec;
	logic [4:0] bc_inc;
	logic [4:0] need;
	logic       seen;

	assign b      = item.in_byte;
	assign ml_dec = methods_left_q - 8'd1;
	assign bc_inc = byte_count_q + 5'd1;
	assign need   = dest_v6_q ? s5hs_pkg::DestLenV6 : s5hs_pkg::DestLenV4;
	assign seen   = no_auth_q | (b == s5hs_pkg::MethodNoAuth);

	always_comb begin
		phase_n        = phase_q;
		byte_count_n   = byte_count_q;
		methods_left_n = methods_left_q;
		no_auth_n      = no_auth_q;
		dest_v6_n      = dest_v6_q;
		fail           = 1'b0;
		burst           = '0;
		burst.kind      = s5hs_pkg::K_NOTREADY;
		burst.len       = s5hs_pkg::IdxW'(1);
		burst.last_flag = 1'b1;

		if (phase_q >= s5hs_pkg::PH_FAIL) begin
			fail = 1'b1;
		end else if (item.req_type) begin
			if (phase_q != s5hs_pkg::PH_OUTCOME) begin
				// outcome out of place: hold state
			end else if (!item.connect_ok) begin
				fail = 1'b1;
			end else begin
				burst.kind     = s5hs_pkg::K_REPLY;
				burst.len      = s5hs_pkg::IdxW'(s5hs_pkg::ReplyMax);
				burst.bytes[0] = s5hs_pkg::SocksVer;
				burst.bytes[1] = item.bound_ok ? s5hs_pkg::RepSuccess
				                               : s5hs_pkg::RepGenFail;
				burst.bytes[2] = s5hs_pkg::RsvByte;
				burst.bytes[3] = s5hs_pkg::AtypV4;
				if (item.bound_ok) begin
					burst.bytes[4] = item.bound_addr[31:24];
					burst.bytes[5] = item.bound_addr[23:16];
					burst.bytes[6] = item.bound_addr[15:8];
					burst.bytes[7] = item.bound_addr[7:0];
					burst.bytes[8] = item.bound_port[15:8];
					burst.bytes[9] = item.bound_port[7:0];
				end
				phase_n      = s5hs_pkg::PH_FORWARD;
				byte_count_n = '0;
			end
		end else begin
			unique case (phase_q)
				s5hs_pkg::PH_GREET_HDR: begin
					if (byte_count_q == '0) begin
						if (b != s5hs_pkg::SocksVer) fail = 1'b1;
						else byte_count_n = 5'd1;
					end else if (b == 8'd0) begin
						fail = 1'b1;
					end else begin
						methods_left_n = b;
						no_auth_n      = 1'b0;
						byte_count_n   = '0;
						phase_n        = s5hs_pkg::PH_METHODS;
					end
				end
				s5hs_pkg::PH_METHODS: begin
					no_auth_n      = seen;
					methods_left_n = ml_dec;
					if (ml_dec != 8'd0) begin
						// more methods to come
					end else if (!seen) begin
						fail = 1'b1;
					end else begin
						phase_n        = s5hs_pkg::PH_REQ_HDR;
						byte_count_n   = '0;
						burst.kind     = s5hs_pkg::K_REPLY;
						burst.len      = s5hs_pkg::IdxW'(2);
						burst.bytes[0] = s5hs_pkg::SocksVer;
						burst.bytes[1] = s5hs_pkg::MethodNoAuth;
					end
				end
				s5hs_pkg::PH_REQ_HDR: begin
					if ((byte_count_q == 5'd0 && b != s5hs_pkg::SocksVer) ||
					    (byte_count_q == 5'd1 && b != s5hs_pkg::CmdConnect) ||
					    (byte_count_q == 5'd2 && b != s5hs_pkg::RsvByte)) begin
						fail = 1'b1;
					end else if (byte_count_q < s5hs_pkg::ReqHdrLast) begin
						byte_count_n = bc_inc;
					end else if (b == s5hs_pkg::AtypV4 || b == s5hs_pkg::AtypV6) begin
						dest_v6_n    = (b == s5hs_pkg::AtypV6);
						byte_count_n = '0;
						phase_n      = s5hs_pkg::PH_DEST;
					end else begin
						fail = 1'b1;
					end
				end
				s5hs_pkg::PH_DEST: begin
					burst.kind      = s5hs_pkg::K_DEST;
					burst.v6        = dest_v6_q;
					burst.bytes[0]  = b;
					burst.last_flag = (bc_inc >= need);
					if (bc_inc >= need) begin
						byte_count_n = '0;
						phase_n      = s5hs_pkg::PH_OUTCOME;
					end else begin
						byte_count_n = bc_inc;
					end
				end
				s5hs_pkg::PH_OUTCOME: begin
					// early client word: drop
				end
				s5hs_pkg::PH_FORWARD: begin
					burst.kind     = s5hs_pkg::K_FORWARD;
					burst.bytes[0] = b;
				end
				default: begin
					fail = 1'b1;
				end
			endcase
		end

		if (fail) begin
			phase_n         = s5hs_pkg::PH_FAIL;
			burst           = '0;
			burst.kind      = s5hs_pkg::K_FAILED;
			burst.len       = s5hs_pkg::IdxW'(1);
			burst.last_flag = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= s5hs_pkg::PH_GREET_HDR;
			byte_count_q   <= '0;
			methods_left_q <= '0;
			no_auth_q      <= 1'b0;
			dest_v6_q      <= 1'b0;
		end else if (go) begin
			phase_q        <= phase_n;
			byte_count_q   <= byte_count_n;
			methods_left_q <= methods_left_n;
			no_auth_q      <= no_auth_n;
			dest_v6_q      <= dest_v6_n;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/s5hs_emit.sv */
// Result register that plays out one run of result words, one word per cycle while rsp_stall is low.
`default_nettype none

module s5hs_emit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire s5hs_pkg::burst_t    burst,
	output logic                     ready,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output s5hs_pkg::out_item_t      rsp_data
);

	logic                        busy_q;
	logic [s5hs_pkg::IdxW-1:0]   idx_q;
	s5hs_pkg::burst_t            burst_q;

	logic out_fire;
	logic beat_last;

	assign beat_last = (idx_q == burst_q.len - s5hs_pkg::IdxW'(1));
	assign out_fire  = busy_q && !rsp_stall;
	assign ready     = !busy_q || (out_fire && beat_last);

	assign rsp_valid           = busy_q;
	assign rsp_data.kind       = burst_q.kind;
	assign rsp_data.out_byte   = burst_q.bytes[idx_q];
	assign rsp_data.addr_is_v6 = burst_q.v6;
	assign rsp_data.last       = beat_last && burst_q.last_flag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (out_fire) begin
			if (beat_last) busy_q <= 1'b0;
			else idx_q <= idx_q + s5hs_pkg::IdxW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) burst_q <= burst;
	end

	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q < burst_q.len))
		else $error("run index beyond run length");

	a_multi_is_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && burst_q.len != s5hs_pkg::IdxW'(1)) |->
		(burst_q.kind == s5hs_pkg::K_REPLY))
		else $error("multi-word run that is not a reply");

	a_drain_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && beat_last && !load) |=> !busy_q)
		else $error("result register still busy after final word");

	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!busy_q || (out_fire && beat_last)))
		else $error("run loaded over words not yet delivered");

endmodule

`default_nettype wire

/* hw/rtl/socks5_connect_handshake_core.sv */
// Top level of the SOCKS5 no-auth CONNECT handshake server core.
// An accepted word is held in the input register, then decoded and loaded into the result
// register once that register is ready; the result register then offers its first result word.
// One input word per cycle when each word yields one result and rsp_stall stays low; a word with
// n results holds later words until its last is taken (greeting reply 2, bound-address reply 10).
// Reset: arst_n clears the phase to greeting header, all counters and flags, and drops held words.
`default_nettype none

module socks5_connect_handshake_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire s5hs_pkg::in_item_t  req_data,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output s5hs_pkg::out_item_t      rsp_data
);

	logic                 valid_s1;
	s5hs_pkg::in_item_t   item_s1;
	logic                 emit_ready;
	logic                 go;
	s5hs_pkg::burst_t     burst;

	assign go        = valid_s1 && emit_ready;
	assign req_stall = valid_s1 && !emit_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) item_s1 <= req_data;
	end

	s5hs_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.item   (item_s1),
		.burst  (burst)
	);

	s5hs_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (go),
		.burst     (burst),
		.ready     (emit_ready),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

endmodule

`default_nettype wire

/* tb/s5hs_checker.sv */
// Scoreboard for the SOCKS5 handshake core: predicts result words from accepted input words.
module s5hs_checker (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	input  wire logic                req_stall,
	input  wire s5hs_pkg::in_item_t  req_data,
	input  wire logic                rsp_valid,
	input  wire logic                rsp_stall,
	input  wire s5hs_pkg::out_item_t rsp_data,
	output int                       mismatches,
	output int                       pending
);
	timeunit 1ns;
	timeprecision 1ps;

	s5hs_pkg::phase_t ph;
	logic [4:0]       cnt;
	logic [7:0]       meth_left;
	logic             no_auth;
	logic             dest_v6;

	s5hs_pkg::out_item_t owed_words[$];
	s5hs_pkg::out_item_t want;
	int                  errors = 0;

	initial begin
		mismatches = 0;
		pending = 0;
	end

	task automatic owe(input s5hs_pkg::kind_t k, input logic [7:0] b, input logic v6,
		input logic lst);
		s5hs_pkg::out_item_t r;
		r.kind = k;
		r.out_byte = b;
		r.addr_is_v6 = v6;
		r.last = lst;
		owed_words.push_back(r);
	endtask

	task automatic enter_fail();
		ph = s5hs_pkg::PH_FAIL;
		owe(s5hs_pkg::K_FAILED, 8'h00, 1'b0, 1'b1);
	endtask

	task automatic step_handshake(input s5hs_pkg::in_item_t w);
		logic [4:0] need;
		logic       done;
		logic [7:0] rep [s5hs_pkg::ReplyMax];
		int         k;
		if (ph >= s5hs_pkg::PH_FAIL) begin
			enter_fail();
			return;
		end
		if (w.req_type) begin
			if (ph != s5hs_pkg::PH_OUTCOME) begin
				owe(s5hs_pkg::K_NOTREADY, 8'h00, 1'b0, 1'b1);
			end else if (!w.connect_ok) begin
				enter_fail();
			end else begin
				rep[0] = s5hs_pkg::SocksVer;
				rep[1] = w.bound_ok ? s5hs_pkg::RepSuccess : s5hs_pkg::RepGenFail;
				rep[2] = s5hs_pkg::RsvByte;
				rep[3] = s5hs_pkg::AtypV4;
				rep[4] = w.bound_ok ? w.bound_addr[31:24] : 8'h00;
				rep[5] = w.bound_ok ? w.bound_addr[23:16] : 8'h00;
				rep[6] = w.bound_ok ? w.bound_addr[15:8] : 8'h00;
				rep[7] = w.bound_ok ? w.bound_addr[7:0] : 8'h00;
				rep[8] = w.bound_ok ? w.bound_port[15:8] : 8'h00;
				rep[9] = w.bound_ok ? w.bound_port[7:0] : 8'h00;
				for (k = 0; k < s5hs_pkg::ReplyMax; k++)
					owe(s5hs_pkg::K_REPLY, rep[k], 1'b0, k == s5hs_pkg::ReplyMax - 1);
				ph = s5hs_pkg::PH_FORWARD;
				cnt = '0;
			end
			return;
		end
		case (ph)
			s5hs_pkg::PH_GREET_HDR: begin
				if (cnt == 0) begin
					if (w.in_byte != s5hs_pkg::SocksVer) begin
						enter_fail();
					end else begin
						cnt = 5'd1;
						owe(s5hs_pkg::K_NOTREADY, 8'h00, 1'b0, 1'b1);
					end
				end else if (w.in_byte == 8'h00) begin
					enter_fail();
				end else begin
					meth_left = w.in_byte;
					no_auth = 1'b0;
					cnt = '0;
					ph = s5hs_pkg::PH_METHODS;
					owe(s5hs_pkg::K_NOTREADY, 8'h00, 1'b0, 1'b1);
				end
			end
			s5hs_pkg::PH_METHODS: begin
				if (w.in_byte == s5hs_pkg::MethodNoAuth)
					no_auth = 1'b1;
				meth_left = meth_left - 8'd1;
				if (meth_left != 0) begin
					owe(s5hs_pkg::K_NOTREADY, 8'h00, 1'b0, 1'b1);
				end else if (!no_auth) begin
					enter_fail();
				end else begin
					ph = s5hs_pkg::PH_REQ_HDR;
					cnt = '0;
					owe(s5hs_pkg::K_REPLY, s5hs_pkg::SocksVer, 1'b0, 1'b0);
					owe(s5hs_pkg::K_REPLY, s5hs_pkg::MethodNoAuth, 1'b0, 1'b1);
				end
			end
			s5hs_pkg::PH_REQ_HDR: begin
				if ((cnt == 0 && w.in_byte != s5hs_pkg::SocksVer) ||
				    (cnt == 1 && w.in_byte != s5hs_pkg::CmdConnect) ||
				    (cnt == 2 && w.in_byte != s5hs_pkg::RsvByte)) begin
					enter_fail();
				end else if (cnt < s5hs_pkg::ReqHdrLast) begin
					cnt = cnt + 5'd1;
					owe(s5hs_pkg::K_NOTREADY, 8'h00, 1'b0, 1'b1);
				end else if (w.in_byte == s5hs_pkg::AtypV4 ||
				             w.in_byte == s5hs_pkg::AtypV6) begin
					dest_v6 = (w.in_byte == s5hs_pkg::AtypV6);
					cnt = '0;
					ph = s5hs_pkg::PH_DEST;
					owe(s5hs_pkg::K_NOTREADY, 8'h00, 1'b0, 1'b1);
				end else begin
					enter_fail();
				end
			end
			s5hs_pkg::PH_DEST: begin
				need = dest_v6 ? s5hs_pkg::DestLenV6 : s5hs_pkg::DestLenV4;
				cnt = cnt + 5'd1;
				done = (cnt >= need);
				if (done) begin
					cnt = '0;
					ph = s5hs_pkg::PH_OUTCOME;
				end
				owe(s5hs_pkg::K_DEST, w.in_byte, dest_v6, done);
			end
			s5hs_pkg::PH_OUTCOME: owe(s5hs_pkg::K_NOTREADY, 8'h00, 1'b0, 1'b1);
			s5hs_pkg::PH_FORWARD: owe(s5hs_pkg::K_FORWARD, w.in_byte, 1'b0, 1'b1);
			default: enter_fail();
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph = s5hs_pkg::PH_GREET_HDR;
			cnt = '0;
			meth_left = '0;
			no_auth = 1'b0;
			dest_v6 = 1'b0;
			owed_words.delete();
			pending <= 0;
		end else begin
			// check the outgoing word before predicting from this edge's input
			if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
				if (owed_words.size() == 0) begin
					errors++;
					$display("%0t: unexpected word: kind %0d byte %02h v6 %0b last %0b",
						$time, rsp_data.kind, rsp_data.out_byte,
						rsp_data.addr_is_v6, rsp_data.last);
				end else begin
					want = owed_words.pop_front();
					if (rsp_data.kind !== want.kind || rsp_data.out_byte !== want.out_byte ||
					    rsp_data.addr_is_v6 !== want.addr_is_v6 ||
					    rsp_data.last !== want.last) begin
						errors++;
						$display("%0t: mismatch: expected kind %0d byte %02h v6 %0b last %0b",
							$time, want.kind, want.out_byte, want.addr_is_v6, want.last);
						$display("%0t: mismatch: actual kind %0d byte %02h v6 %0b last %0b",
							$time, rsp_data.kind, rsp_data.out_byte,
							rsp_data.addr_is_v6, rsp_data.last);
					end
				end
			end
			if (req_valid === 1'b1 && req_stall === 1'b0)
				step_handshake(req_data);
			pending <= owed_words.size();
			mismatches <= errors;
		end
	end

endmodule

/* tb/testbench.sv */
// Top of the SOCKS5 handshake core testbench: clock, reset, stimulus and verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ItemCount = 230;
	localparam int CycleLimit = 300000;
	localparam logic [7:0] AtypDomain = 8'h03;

	typedef enum int {
		FLAW_NONE,
		FLAW_VER,
		FLAW_NMETH,
		FLAW_NOAUTH,
		FLAW_REQ_VER,
		FLAW_CMD,
		FLAW_RSV,
		FLAW_ATYP,
		FLAW_REFUSED
	} flaw_t;

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_stall;
	s5hs_pkg::in_item_t  req_data;
	logic                rsp_valid;
	logic                rsp_stall;
	s5hs_pkg::out_item_t rsp_data;
	int                  mismatches;
	int                  pending;

	int        words_sent = 0;
	int        calm_left = 0;

	socks5_connect_handshake_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	s5hs_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_data   (req_data),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp_data   (rsp_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CycleLimit) @(posedge clk);
		$display("** socks5_connect_handshake_core: FAILED **");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] other_than(input logic [7:0] v);
		logic [7:0] b;
		do b = 8'($urandom); while (b == v);
		return b;
	endfunction

	function automatic s5hs_pkg::in_item_t client_word(input logic [7:0] b);
		s5hs_pkg::in_item_t w;
		w.req_type = 1'b0;
		w.in_byte = b;
		w.connect_ok = 1'($urandom);
		w.bound_ok = 1'($urandom);
		w.bound_addr = $urandom;
		w.bound_port = 16'($urandom);
		return w;
	endfunction

	function automatic s5hs_pkg::in_item_t outcome_word(input logic cok, input logic bok);
		s5hs_pkg::in_item_t w;
		w.req_type = 1'b1;
		w.in_byte = 8'($urandom);
		w.connect_ok = cok;
		w.bound_ok = bok;
		w.bound_addr = $urandom;
		w.bound_port = 16'($urandom);
		case ($urandom_range(0, 5))
			0: begin
				w.bound_addr = '0;
				w.bound_port = '0;
			end
			1: begin
				w.bound_addr = '1;
				w.bound_port = '1;
			end
			default: ;
		endcase
		return w;
	endfunction

	task automatic send_word(input s5hs_pkg::in_item_t w);
		int gap;
		req_data <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall !== 1'b0)
			@(posedge clk);
		words_sent++;
		if (calm_left > 0) begin
			calm_left--;
			gap = 0;
		end else begin
			gap = pick_gap();
			if ($urandom_range(0, 29) == 0)
				calm_left = $urandom_range(15, 30);
		end
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold off until every predicted word has come out
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int         run;
		rsp_stall <= 1'b0;
		forever begin
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
			rsp_stall <= 1'b0;
			repeat (run) @(posedge clk);
			run = pick_gap();
			if (run > 0) begin
				rsp_stall <= 1'b1;
				repeat (run) @(posedge clk);
			end
		end
	end

	initial begin
		flaw_t      flaw;
		int         nmeth;
		int         nm;
		int         zero_at;
		logic       v6;
		logic [7:0] b;

		req_valid <= 1'b0;
		req_data <= '0;
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one session per run: most are clean, some break at one chosen point
		flaw = FLAW_NONE;
		if ($urandom_range(0, 3) == 0)
			flaw = flaw_t'($urandom_range(FLAW_VER, FLAW_REFUSED));

		// outcome before any greeting is out of place
		send_word(outcome_word(1'($urandom), 1'($urandom)));
		send_word(client_word(flaw == FLAW_VER ? other_than(s5hs_pkg::SocksVer)
		                                       : s5hs_pkg::SocksVer));

		if (flaw == FLAW_NMETH)
			nmeth = 0;
		else if ($urandom_range(0, 15) == 0)
			nmeth = 255;
		else
			nmeth = $urandom_range(1, 6);
		send_word(client_word(nmeth[7:0]));

		nm = (nmeth == 0) ? 3 : nmeth;
		zero_at = $urandom_range(0, nm - 1);
		for (int i = 0; i < nm; i++) begin
			if (i == zero_at && flaw != FLAW_NOAUTH)
				b = s5hs_pkg::MethodNoAuth;
			else
				b = other_than(s5hs_pkg::MethodNoAuth);
			send_word(client_word(b));
			if (i == 0 && nm > 1)
				send_word(outcome_word(1'($urandom), 1'($urandom)));
		end
		wait_drained();

		send_word(client_word(flaw == FLAW_REQ_VER ? other_than(s5hs_pkg::SocksVer)
		                                           : s5hs_pkg::SocksVer));
		send_word(client_word(flaw == FLAW_CMD ? other_than(s5hs_pkg::CmdConnect)
		                                       : s5hs_pkg::CmdConnect));
		send_word(client_word(flaw == FLAW_RSV ? other_than(s5hs_pkg::RsvByte)
		                                       : s5hs_pkg::RsvByte));

		v6 = 1'($urandom);
		b = v6 ? s5hs_pkg::AtypV6 : s5hs_pkg::AtypV4;
		if (flaw == FLAW_ATYP) begin
			if ($urandom_range(0, 1) == 0)
				b = AtypDomain;
			else
				do b = 8'($urandom); while (b == s5hs_pkg::AtypV4 || b == s5hs_pkg::AtypV6);
		end
		send_word(client_word(b));

		repeat (v6 ? s5hs_pkg::DestLenV6 : s5hs_pkg::DestLenV4)
			send_word(client_word(8'($urandom)));
		wait_drained();

		// drop client bytes that come before the connect outcome
		repeat ($urandom_range(1, 2))
			send_word(client_word(8'($urandom)));
		send_word(outcome_word(flaw != FLAW_REFUSED, 1'($urandom)));

		send_word(client_word(8'h00));
		send_word(client_word(8'hFF));
		while (words_sent < ItemCount) begin
			if ($urandom_range(0, 7) == 0)
				send_word(outcome_word(1'($urandom), 1'($urandom)));
			else
				send_word(client_word(8'($urandom)));
		end

		wait_drained();
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("** socks5_connect_handshake_core: PASSED **");
		else
			$display("** socks5_connect_handshake_core: FAILED **");
		$finish;
	end

endmodule
